// ===== src/tmmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-motor move timer package
// Shared widths, codes and bus layouts for the two-motor move timer.
// ----------------------------------------------------------------------------
package tmmt_pkg;

    localparam int unsigned DIR_W    = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [BYTE_W-1:0] CNT_MAX = 8'd255;

    // Direction codes of a move transaction.
    localparam logic [DIR_W-1:0] DIR_FWD   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BACK  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_STOP  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_CW    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_ACW   = 3'd4;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd5;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd6;

    // Command kinds carried in the slave-side tuser.
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UNITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_UNITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PINGPONG_THRESH = 3'd4;

    typedef enum logic [1:0] {
        ACT_STOP = 2'd0,
        ACT_FWD  = 2'd1,
        ACT_BACK = 2'd2
    } t_action;

    typedef struct packed {
        logic [BYTE_W-1:0] speed;
        logic [BYTE_W-1:0] amount;
        logic [DIR_W-1:0]  direction;
        logic              cmd;
    } t_item;

endpackage

// ===== src/two_motor_move_timer_core.sv =====
// ----------------------------------------------------------------------------
// Two-motor move timer core
// Sets H-bridge levels and a run count from move transactions, counts the
// run down on tick transactions, and keeps move repeat statistics.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake                 | Payload
// s        | in        | i_s_tvalid / o_s_tready   | tuser cmd, tdata move fields
// m        | out       | o_m_tvalid / i_m_tready   | tdata result fields
// cfg      | in        | i_cfg_valid / o_cfg_ready | register index and data
//
// One transaction per cycle while the result is not stalled.
// The input register feeds one pass of logic into the result register.
// A stalled result holds the pipeline, and the input register still takes one
// more transaction. Synchronous reset restores all state but the input and result data.
// ----------------------------------------------------------------------------
module two_motor_move_timer_core
    import tmmt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: direction[2:0], amount[10:3], speed[18:11], zero fill above
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    // tuser: cmd
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: left_drive_a, left_drive_b, right_drive_a, right_drive_b, moving,
    // step_repeat, rotate_repeat, rotate_pingpong, last_direction[10:8],
    // last_amount[18:11], ticks_left[34:19], rejected[35], zero fill above
    output logic [M_DATA_W-1:0]  o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic [BYTE_W-1:0] r_step_units;
    logic [BYTE_W-1:0] r_rotate_units;
    logic [BYTE_W-1:0] r_step_thresh;
    logic [BYTE_W-1:0] r_rotate_thresh;
    logic [BYTE_W-1:0] r_pingpong_thresh;

    logic [COUNT_W-1:0] r_run_count, n_run_count;
    logic [BYTE_W-1:0]  r_speed, n_speed;
    t_action            r_left, n_left;
    t_action            r_right, n_right;
    logic [BYTE_W-1:0]  r_repeat, n_repeat;
    logic [BYTE_W-1:0]  r_alt, n_alt;
    logic [DIR_W-1:0]   r_prev_dir, n_prev_dir;
    logic [BYTE_W-1:0]  r_prev_amount, n_prev_amount;
    logic               r_flag_step, n_flag_step;
    logic               r_flag_rotate, n_flag_rotate;
    logic               r_flag_pingpong, n_flag_pingpong;
    logic               n_rejected;

    logic               out_free;
    logic               advance;
    logic               is_rot;
    logic               same_dir;
    logic [BYTE_W-1:0]  units;
    logic [COUNT_W-1:0] product;
    logic [M_DATA_W-1:0] n_out_data;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign is_rot   = (r_in.direction == DIR_CW) || (r_in.direction == DIR_ACW);
    assign same_dir = (r_prev_dir == r_in.direction);
    assign units    = is_rot ? r_rotate_units : r_step_units;
    assign product  = {{(COUNT_W-BYTE_W){1'b0}}, r_in.amount}
                    * {{(COUNT_W-BYTE_W){1'b0}}, units};

    always_comb begin
        n_run_count     = r_run_count;
        n_speed         = r_speed;
        n_left          = r_left;
        n_right         = r_right;
        n_repeat        = r_repeat;
        n_alt           = r_alt;
        n_prev_dir      = r_prev_dir;
        n_prev_amount   = r_prev_amount;
        n_flag_step     = r_flag_step;
        n_flag_rotate   = r_flag_rotate;
        n_flag_pingpong = r_flag_pingpong;
        n_rejected      = 1'b0;

        if (r_in.cmd == CMD_MOVE) begin
            if (r_in.amount == '0) begin
                n_rejected = 1'b1;
            end else begin
                unique case (r_in.direction)
                    DIR_FWD: begin
                        n_left      = ACT_FWD;
                        n_right     = ACT_FWD;
                        n_run_count = product;
                    end
                    DIR_BACK: begin
                        n_left      = ACT_BACK;
                        n_right     = ACT_BACK;
                        n_run_count = product;
                    end
                    DIR_STOP: begin
                        n_left      = ACT_STOP;
                        n_right     = ACT_STOP;
                        n_run_count = product;
                    end
                    DIR_CW: begin
                        n_left      = ACT_FWD;
                        n_right     = ACT_BACK;
                        n_run_count = product;
                    end
                    DIR_ACW: begin
                        n_left      = ACT_BACK;
                        n_right     = ACT_FWD;
                        n_run_count = product;
                    end
                    default: begin
                    end
                endcase
                n_speed = r_in.speed;

                if (!same_dir) begin
                    n_repeat      = '0;
                    n_flag_step   = 1'b0;
                    n_flag_rotate = 1'b0;
                end else if (r_repeat != CNT_MAX) begin
                    n_repeat = r_repeat + 8'd1;
                end

                if (r_in.direction == DIR_FWD) begin
                    n_flag_step = (n_repeat >= r_step_thresh);
                end else if (is_rot) begin
                    n_flag_rotate = (n_repeat >= r_rotate_thresh);
                end

                if (!is_rot) begin
                    n_alt = '0;
                end else if (!same_dir && (r_alt != CNT_MAX)) begin
                    n_alt = r_alt + 8'd1;
                end

                n_flag_pingpong = (n_alt >= r_pingpong_thresh);
                n_prev_dir      = r_in.direction;
                n_prev_amount   = r_in.amount;
            end
        end else if (r_speed != '0) begin
            if (r_run_count == '0) begin
                n_run_count = '0;
                n_speed     = '0;
                n_left      = ACT_STOP;
                n_right     = ACT_STOP;
            end else begin
                n_run_count = r_run_count - 16'd1;
            end
        end

        n_out_data = {
            {(M_DATA_W-36){1'b0}},
            n_rejected,
            n_run_count,
            n_prev_amount,
            n_prev_dir,
            n_flag_pingpong,
            n_flag_rotate,
            n_flag_step,
            (n_speed != '0),
            (n_right == ACT_BACK),
            (n_right == ACT_FWD),
            (n_left == ACT_BACK),
            (n_left == ACT_FWD)
        };
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_step_units      <= 8'd10;
            r_rotate_units    <= 8'd10;
            r_step_thresh     <= 8'd3;
            r_rotate_thresh   <= 8'd3;
            r_pingpong_thresh <= 8'd3;
            r_run_count       <= '0;
            r_speed           <= '0;
            r_left            <= ACT_STOP;
            r_right           <= ACT_STOP;
            r_repeat          <= '0;
            r_alt             <= '0;
            r_prev_dir        <= DIR_FWD;
            r_prev_amount     <= '0;
            r_flag_step       <= 1'b0;
            r_flag_rotate     <= 1'b0;
            r_flag_pingpong   <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_run_count     <= n_run_count;
                r_speed         <= n_speed;
                r_left          <= n_left;
                r_right         <= n_right;
                r_repeat        <= n_repeat;
                r_alt           <= n_alt;
                r_prev_dir      <= n_prev_dir;
                r_prev_amount   <= n_prev_amount;
                r_flag_step     <= n_flag_step;
                r_flag_rotate   <= n_flag_rotate;
                r_flag_pingpong <= n_flag_pingpong;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEP_UNITS:      r_step_units      <= i_cfg_data;
                    CFG_ROTATE_UNITS:    r_rotate_units    <= i_cfg_data;
                    CFG_STEP_THRESH:     r_step_thresh     <= i_cfg_data;
                    CFG_ROTATE_THRESH:   r_rotate_thresh   <= i_cfg_data;
                    CFG_PINGPONG_THRESH: r_pingpong_thresh <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.cmd       <= i_s_tuser;
            r_in.direction <= i_s_tdata[2:0];
            r_in.amount    <= i_s_tdata[10:3];
            r_in.speed     <= i_s_tdata[18:11];
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
